[sv/assert_macros.svh]
// Assertion macros shared by the checker files.
// Clocked on the rising edge, disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle
`define ASSERT_NOW(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ksa_pkg.sv]
// Shared types, key codes and helpers for the keyboard scan translator.
// No dependencies.
`timescale 1ns / 1ps

package ksa_pkg;

	typedef enum logic [1:0] {
		REQ_SCAN = 2'd0,
		REQ_READ = 2'd1,
		REQ_LOAD = 2'd2
	} req_t;

	localparam logic [7:0] REL_BIT    = 8'h80;
	localparam logic [7:0] CODE_MASK  = 8'h7F;
	localparam logic [7:0] KEY_LSHIFT = 8'h2A;
	localparam logic [7:0] KEY_RSHIFT = 8'h36;
	localparam logic [7:0] KEY_CAPS   = 8'h3A;
	localparam logic [7:0] KEY_F1     = 8'h3B;
	localparam logic [7:0] KEY_F2     = 8'h3C;
	localparam logic [7:0] KEY_F3     = 8'h3D;

	localparam logic [1:0] FKEY_NONE = 2'd0;
	localparam logic [1:0] FKEY_F1   = 2'd1;
	localparam logic [1:0] FKEY_F2   = 2'd2;
	localparam logic [1:0] FKEY_F3   = 2'd3;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic       load;
		logic [7:0] wdata;
	} ring_ctrl_t;

	function automatic logic [7:0] swap_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

endpackage

[sv/ksa_ring.sv]
// Character ring buffer: memory, read/write pointers and fill count.
// Uses ksa_pkg::ring_ctrl_t. Read data is registered on load, write-first.
`timescale 1ns / 1ps

module ksa_ring #(
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ksa_pkg::ring_ctrl_t          ctrl,
	output logic [7:0]                   rd_data,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [7:0]    mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW-1:0] rd_ptr_d;
	logic [CW-1:0] cnt_q;
	logic [7:0]    rd_data_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign rd_ptr_d = ctrl.pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_d;
			if (ctrl.push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
				cnt_q    <= cnt_q + CW'(1);
			end else if (ctrl.pop) begin
				cnt_q    <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[wr_ptr_q] <= ctrl.wdata;
		end
		if (ctrl.load) begin
			rd_data_q <= (ctrl.push && wr_ptr_q == rd_ptr_d) ? ctrl.wdata : mem[rd_ptr_d];
		end
	end

	assign rd_data = rd_data_q;
	assign count   = cnt_q;

endmodule

[sv/keyboard_scan_to_ascii_fifo.sv]
// Keyboard scan code translator with character buffer, top level.
// Uses ksa_pkg and ksa_ring.
`timescale 1ns / 1ps

// One request per clock is taken in steady state while m_tready stays high. Each result
// passes through the input register, then the result register, before it is offered.
// While a result waits on m_tready, one more request is taken into the input
// register, and s_tready then stays low until the waiting result leaves. The rate is set by
// the single pass through the translation tables and the ring buffer, each a memory with one
// write and one registered read per cycle, bypassed write-first so a request may follow a
// load or a push at once.
// The translation tables and the buffer contents are undefined until written; there is no
// clearing pass after reset.
module keyboard_scan_to_ascii_fifo #(
	parameter int BUF_DEPTH     = 64,
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// scan_code[7:0], table_select[8], table_index[14:9], table_char[22:15], zero pad
	input  logic [23:0]         s_tdata,
	// req_type[1:0]
	input  logic [1:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// char_valid, char_out[7], read_empty, full_drop, function_key[2], fill_level, zero pad
	output logic [((12 + $clog2(BUF_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int CW    = $clog2(BUF_DEPTH + 1);
	localparam int OUT_W = ((12 + CW + 7) / 8) * 8;
	localparam int TW    = $clog2(TABLE_ENTRIES);
	localparam logic [8:0] TBL_LIM = 9'(TABLE_ENTRIES);

	logic acc;
	logic adv;

	logic                 valid_s1;
	ksa_pkg::req_t        req_s1;
	logic [7:0]           code_s1;
	logic                 sel_s1;
	logic [5:0]           idx_s1;
	logic [7:0]           tchar_s1;
	logic [7:0]           plain_rd_s1;
	logic [7:0]           upper_rd_s1;

	logic [7:0] plain_mem [TABLE_ENTRIES];
	logic [7:0] upper_mem [TABLE_ENTRIES];
	logic [TW-1:0] tbl_raddr;
	logic [TW-1:0] tbl_waddr;
	logic          tbl_we;

	logic shift_q, caps_q, shift_d, caps_d;

	ksa_pkg::ring_ctrl_t ring_ctrl;
	logic [7:0]          ring_rd;
	logic [CW-1:0]       count;
	logic                push, pop;
	logic [7:0]          xchar;

	logic          r_valid, r_empty, r_drop;
	logic [6:0]    r_char;
	logic [1:0]    r_fkey;
	logic [CW-1:0] r_fill;

	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	assign adv      = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign acc      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1   <= ksa_pkg::req_t'(s_tuser);
			code_s1  <= s_tdata[7:0];
			sel_s1   <= s_tdata[8];
			idx_s1   <= s_tdata[14:9];
			tchar_s1 <= s_tdata[22:15];
		end
	end

	// translation tables, write-first so a lookup right after a load sees it
	assign tbl_raddr = s_tdata[TW-1:0];
	assign tbl_waddr = TW'(idx_s1);

	always_ff @(posedge clk) begin
		if (adv && tbl_we && !sel_s1) begin
			plain_mem[tbl_waddr] <= tchar_s1;
		end
		if (adv && tbl_we && sel_s1) begin
			upper_mem[tbl_waddr] <= tchar_s1;
		end
		if (acc) begin
			plain_rd_s1 <= (adv && tbl_we && !sel_s1 && tbl_waddr == tbl_raddr)
				? tchar_s1 : plain_mem[tbl_raddr];
			upper_rd_s1 <= (adv && tbl_we && sel_s1 && tbl_waddr == tbl_raddr)
				? tchar_s1 : upper_mem[tbl_raddr];
		end
	end

	always_comb begin
		push    = 1'b0;
		pop     = 1'b0;
		tbl_we  = 1'b0;
		shift_d = shift_q;
		caps_d  = caps_q;
		r_valid = 1'b0;
		r_char  = '0;
		r_empty = 1'b0;
		r_drop  = 1'b0;
		r_fkey  = ksa_pkg::FKEY_NONE;
		xchar   = shift_q ? upper_rd_s1 : plain_rd_s1;
		if (caps_q) begin
			xchar = ksa_pkg::swap_case(xchar);
		end
		unique case (req_s1)
			ksa_pkg::REQ_SCAN: begin
				if ((code_s1 & ksa_pkg::REL_BIT) != 8'h00) begin
					if ((code_s1 & ksa_pkg::CODE_MASK) == ksa_pkg::KEY_LSHIFT ||
					    (code_s1 & ksa_pkg::CODE_MASK) == ksa_pkg::KEY_RSHIFT) begin
						shift_d = 1'b0;
					end
				end else if (code_s1 == ksa_pkg::KEY_LSHIFT || code_s1 == ksa_pkg::KEY_RSHIFT) begin
					shift_d = 1'b1;
				end else if (code_s1 == ksa_pkg::KEY_CAPS) begin
					caps_d = !caps_q;
				end else if (code_s1 == ksa_pkg::KEY_F1) begin
					r_fkey = ksa_pkg::FKEY_F1;
				end else if (code_s1 == ksa_pkg::KEY_F2) begin
					r_fkey = ksa_pkg::FKEY_F2;
				end else if (code_s1 == ksa_pkg::KEY_F3) begin
					r_fkey = ksa_pkg::FKEY_F3;
				end else if ({1'b0, code_s1} < TBL_LIM) begin
					if (count == CW'(BUF_DEPTH)) begin
						r_drop = 1'b1;
					end else begin
						push = 1'b1;
					end
				end
			end
			ksa_pkg::REQ_READ: begin
				if (count == '0) begin
					r_empty = 1'b1;
				end else begin
					pop     = 1'b1;
					r_valid = 1'b1;
					r_char  = ring_rd[6:0];
				end
			end
			ksa_pkg::REQ_LOAD: begin
				tbl_we = 1'b1;
			end
			default: begin
			end
		endcase
		if (push) begin
			r_fill = count + CW'(1);
		end else if (pop) begin
			r_fill = count - CW'(1);
		end else begin
			r_fill = count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
		end else if (adv) begin
			shift_q <= shift_d;
			caps_q  <= caps_d;
		end
	end

	assign ring_ctrl.push  = adv && push;
	assign ring_ctrl.pop   = adv && pop;
	assign ring_ctrl.load  = acc;
	assign ring_ctrl.wdata = xchar;

	ksa_ring #(
		.DEPTH (BUF_DEPTH)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ring_ctrl),
		.rd_data (ring_rd),
		.count   (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= OUT_W'({r_fill, r_fkey, r_drop, r_empty, r_char, r_valid});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[sv/ksa_checker.sv]
// Port-level checks for keyboard_scan_to_ascii_fifo, bound to the top level.
// Uses assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ksa_checker #(
	parameter int BUF_DEPTH = 64
) (
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [((12 + $clog2(BUF_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int CW = $clog2(BUF_DEPTH + 1);

	logic [CW-1:0] fill;
	assign fill = m_tdata[12 +: CW];

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
	`ASSERT_NOW(a_char_xor_empty, clk, arst_n, !(m_tvalid && m_tdata[0] && m_tdata[8]), "char and empty both set")
	`ASSERT_NOW(a_empty_fill, clk, arst_n, !(m_tvalid && m_tdata[8]) || fill == '0, "empty read with nonzero fill")
	`ASSERT_NOW(a_drop_full, clk, arst_n, !(m_tvalid && m_tdata[9]) || fill == CW'(BUF_DEPTH), "drop while not full")

endmodule

bind keyboard_scan_to_ascii_fifo ksa_checker #(
	.BUF_DEPTH (BUF_DEPTH)
) u_ksa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
